[rtl/vector4_normalize_defines.svh]
// Assertion macros used by the top level of the vector normaliser RTL.
`ifndef VECTOR4_NORMALIZE_DEFINES_SVH
`define VECTOR4_NORMALIZE_DEFINES_SVH

// Condition a must be followed by condition b in the same cycle.
`define V4N_ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("vector4_normalize: same-cycle check failed");

// Condition a must be followed by condition b in the next cycle.
`define V4N_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("vector4_normalize: next-cycle check failed");

`endif

[rtl/v4n_pkg.sv]
// Types and constants of the vector normaliser.
`default_nettype none
package v4n_pkg;
  localparam int Lanes     = 4;
  localparam int CompW     = 32;
  localparam int SqW       = 64;
  localparam int SumW      = 65;
  localparam int RadW      = 66;
  localparam int RootW     = 33;
  localparam int RemW      = 36;
  localparam int SqrtSteps = 33;
  localparam int QuoW      = 31;
  localparam int DremW     = 34;
  localparam int DivSteps  = 31;
  localparam int Latency   = 3 + SqrtSteps + DivSteps + 1;

  typedef struct packed {
    logic [Lanes-1:0][CompW-1:0] mag;
    logic [Lanes-1:0]            neg;
  } side_t;
endpackage
`default_nettype wire

[rtl/v4n_if.sv]
// Stream interfaces of the vector normaliser.
`default_nettype none
interface v4n_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] comp_x;
  logic [31:0] comp_y;
  logic [31:0] comp_z;
  logic [31:0] comp_w;
  modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface v4n_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] unit_x;
  logic [31:0] unit_y;
  logic [31:0] unit_z;
  logic [31:0] unit_w;
  logic [32:0] magnitude;
  logic        zero_length;
  modport source (output valid, unit_x, unit_y, unit_z, unit_w, magnitude, zero_length,
                  input ready);
  modport sink (input valid, unit_x, unit_y, unit_z, unit_w, magnitude, zero_length,
                output ready);
endinterface
`default_nettype wire

[rtl/vector4_normalize.sv]
// Top level of the four-component fixed-point vector normaliser.
//
// Channel  Direction  Transfer payload
// in_ch    sink       comp_x, comp_y, comp_z, comp_w (signed Q16.16)
// out_ch   source     unit_x..unit_w (signed Q2.30), magnitude (Q17.16), zero_length
//
// Every transfer in yields one transfer out.
// One vector is accepted per cycle unless the output stalls; the rate is set by the
// single pipeline that runs through the four squaring lanes, a 33-stage square root
// and four 31-stage dividers, each producing one result bit per stage.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears only the stage valid bits; payload registers are not reset.
`default_nettype none
`include "vector4_normalize_defines.svh"
module vector4_normalize (
  input  wire logic  clk,
  input  wire logic  rst_n,
  v4n_in_if.sink     in_ch,
  v4n_out_if.source  out_ch
);
  localparam int Lat = v4n_pkg::Latency;

  // One valid bit per pipeline stage; all stages advance together.
  logic [Lat-1:0] vld_r;
  logic           adv;

  assign adv         = !vld_r[Lat-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Lat-2:0], in_ch.valid};
    end
  end

  // Stage one: split each component into sign and absolute value.
  logic [v4n_pkg::CompW-1:0] comp [v4n_pkg::Lanes];
  logic [v4n_pkg::CompW-1:0] abs_r [v4n_pkg::Lanes];
  logic [v4n_pkg::Lanes-1:0] neg_r;

  assign comp[0] = in_ch.comp_x;
  assign comp[1] = in_ch.comp_y;
  assign comp[2] = in_ch.comp_z;
  assign comp[3] = in_ch.comp_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < v4n_pkg::Lanes; i++) begin
        neg_r[i] <= comp[i][v4n_pkg::CompW-1];
        abs_r[i] <= comp[i][v4n_pkg::CompW-1] ? (~comp[i] + 1'b1) : comp[i];
      end
    end
  end

  // Stage two: the squaring lanes, with sign and magnitude carried alongside.
  logic [v4n_pkg::SqW-1:0]   sq [v4n_pkg::Lanes];
  v4n_pkg::side_t            side2_r;

  for (genvar i = 0; i < v4n_pkg::Lanes; i++) begin : g_sq
    v4n_square u_sq (
      .clk (clk),
      .adv (adv),
      .a   (abs_r[i]),
      .sq  (sq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < v4n_pkg::Lanes; i++) begin
        side2_r.mag[i] <= abs_r[i];
      end
      side2_r.neg <= neg_r;
    end
  end

  // Stage three: merge the lanes into the exact 65-bit sum of squares.
  logic [v4n_pkg::SumW-1:0] sum_r;
  v4n_pkg::side_t           side3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r   <= ({1'b0, sq[0]} + {1'b0, sq[1]}) + ({1'b0, sq[2]} + {1'b0, sq[3]});
      side3_r <= side2_r;
    end
  end

  // Square root of the sum gives the length.
  logic [v4n_pkg::RootW-1:0] root;
  v4n_pkg::side_t            side_q;

  v4n_sqrt u_sqrt (
    .clk      (clk),
    .adv      (adv),
    .rad      (sum_r),
    .side_in  (side3_r),
    .root     (root),
    .side_out (side_q)
  );

  // Each lane divides its absolute component by the length.
  logic [v4n_pkg::QuoW-1:0]  quo [v4n_pkg::Lanes];
  logic [v4n_pkg::Lanes-1:0] negd;

  for (genvar i = 0; i < v4n_pkg::Lanes; i++) begin : g_div
    v4n_div u_div (
      .clk     (clk),
      .adv     (adv),
      .num     (side_q.mag[i]),
      .neg_in  (side_q.neg[i]),
      .den     (root),
      .quo     (quo[i]),
      .neg_out (negd[i])
    );
  end

  // The length travels beside the dividers so it arrives with the quotients.
  logic [v4n_pkg::RootW-1:0] magd_r [v4n_pkg::DivSteps];

  always_ff @(posedge clk) begin
    if (adv) begin
      magd_r[0] <= root;
      for (int k = 1; k < v4n_pkg::DivSteps; k++) begin
        magd_r[k] <= magd_r[k-1];
      end
    end
  end

  // Output register: restore signs and force zero units for a zero vector.
  logic [v4n_pkg::RootW-1:0] magd;
  logic                      zero;
  logic [v4n_pkg::CompW-1:0] unit_r [v4n_pkg::Lanes];
  logic [v4n_pkg::RootW-1:0] mag_r;
  logic                      zero_r;

  assign magd = magd_r[v4n_pkg::DivSteps-1];
  assign zero = (magd == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < v4n_pkg::Lanes; i++) begin
        if (zero) begin
          unit_r[i] <= '0;
        end else if (negd[i]) begin
          unit_r[i] <= ~{1'b0, quo[i]} + 1'b1;
        end else begin
          unit_r[i] <= {1'b0, quo[i]};
        end
      end
      mag_r  <= magd;
      zero_r <= zero;
    end
  end

  assign out_ch.valid       = vld_r[Lat-1];
  assign out_ch.unit_x      = unit_r[0];
  assign out_ch.unit_y      = unit_r[1];
  assign out_ch.unit_z      = unit_r[2];
  assign out_ch.unit_w      = unit_r[3];
  assign out_ch.magnitude   = mag_r;
  assign out_ch.zero_length = zero_r;

  // A transfer in must occupy the first stage on the next cycle.
  `V4N_ASSERT_NEXT(a_in_enters, clk, rst_n, in_ch.valid && in_ch.ready, vld_r[0])
  // A zero vector delivers zero unit components.
  `V4N_ASSERT_SAME(a_zero_units, clk, rst_n, out_ch.valid && out_ch.zero_length,
    out_ch.unit_x == 32'd0 && out_ch.unit_y == 32'd0 &&
    out_ch.unit_z == 32'd0 && out_ch.unit_w == 32'd0)
  // The flag and the length agree.
  `V4N_ASSERT_SAME(a_zero_mag, clk, rst_n, out_ch.valid,
    out_ch.zero_length == (out_ch.magnitude == 33'd0))
endmodule
`default_nettype wire

[rtl/v4n_square.sv]
// One lane squarer: registered 32 by 32 bit product.
`default_nettype none
module v4n_square (
  input  wire logic                       clk,
  input  wire logic                       adv,
  input  wire logic [v4n_pkg::CompW-1:0]  a,
  output logic      [v4n_pkg::SqW-1:0]    sq
);
  logic [v4n_pkg::SqW-1:0] sq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= {{(v4n_pkg::SqW-v4n_pkg::CompW){1'b0}}, a} *
              {{(v4n_pkg::SqW-v4n_pkg::CompW){1'b0}}, a};
    end
  end

  assign sq = sq_r;
endmodule
`default_nettype wire

[rtl/v4n_sqrt.sv]
// Pipelined digit-by-digit square root, one root bit per stage.
`default_nettype none
module v4n_sqrt (
  input  wire logic                      clk,
  input  wire logic                      adv,
  input  wire logic [v4n_pkg::SumW-1:0]  rad,
  input  wire v4n_pkg::side_t            side_in,
  output logic      [v4n_pkg::RootW-1:0] root,
  output v4n_pkg::side_t                 side_out
);
  logic [v4n_pkg::RadW-1:0]  rad_r  [v4n_pkg::SqrtSteps];
  logic [v4n_pkg::RemW-1:0]  rem_r  [v4n_pkg::SqrtSteps];
  logic [v4n_pkg::RootW-1:0] root_r [v4n_pkg::SqrtSteps];
  v4n_pkg::side_t            side_r [v4n_pkg::SqrtSteps];

  for (genvar k = 0; k < v4n_pkg::SqrtSteps; k++) begin : g_stage
    logic [v4n_pkg::RadW-1:0]  rad_i;
    logic [v4n_pkg::RemW-1:0]  rem_i;
    logic [v4n_pkg::RootW-1:0] root_i;
    v4n_pkg::side_t            side_i;
    logic [v4n_pkg::RemW-1:0]  rem_sh;
    logic [v4n_pkg::RemW-1:0]  trial;
    logic                      take;

    if (k == 0) begin : g_first
      assign rad_i  = {1'b0, rad};
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    // Bring down the next pair of radicand bits and try root*4+1.
    assign rem_sh = {rem_i[v4n_pkg::RemW-3:0],
                     rad_i[v4n_pkg::RadW-1-2*k], rad_i[v4n_pkg::RadW-2-2*k]};
    assign trial  = {1'b0, root_i, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[k]  <= rad_i;
        side_r[k] <= side_i;
        rem_r[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {root_i[v4n_pkg::RootW-2:0], take};
      end
    end
  end

  assign root     = root_r[v4n_pkg::SqrtSteps-1];
  assign side_out = side_r[v4n_pkg::SqrtSteps-1];
endmodule
`default_nettype wire

[rtl/v4n_div.sv]
// One lane restoring divider, one quotient bit per stage: floor(num * 2^30 / den).
`default_nettype none
module v4n_div (
  input  wire logic                      clk,
  input  wire logic                      adv,
  input  wire logic [v4n_pkg::CompW-1:0] num,
  input  wire logic                      neg_in,
  input  wire logic [v4n_pkg::RootW-1:0] den,
  output logic      [v4n_pkg::QuoW-1:0]  quo,
  output logic                           neg_out
);
  logic [v4n_pkg::DremW-1:0] rem_r [v4n_pkg::DivSteps];
  logic [v4n_pkg::QuoW-1:0]  quo_r [v4n_pkg::DivSteps];
  logic [v4n_pkg::RootW-1:0] den_r [v4n_pkg::DivSteps];
  logic                      neg_r [v4n_pkg::DivSteps];

  for (genvar k = 0; k < v4n_pkg::DivSteps; k++) begin : g_stage
    logic [v4n_pkg::DremW-1:0] rem_sh;
    logic [v4n_pkg::DremW-1:0] den_x;
    logic [v4n_pkg::QuoW-1:0]  quo_i;
    logic [v4n_pkg::RootW-1:0] den_i;
    logic                      neg_i;
    logic                      take;

    // The numerator never exceeds the length, so the first step starts unshifted.
    if (k == 0) begin : g_first
      assign rem_sh = {{(v4n_pkg::DremW-v4n_pkg::CompW){1'b0}}, num};
      assign quo_i  = '0;
      assign den_i  = den;
      assign neg_i  = neg_in;
    end else begin : g_next
      assign rem_sh = {rem_r[k-1][v4n_pkg::DremW-2:0], 1'b0};
      assign quo_i  = quo_r[k-1];
      assign den_i  = den_r[k-1];
      assign neg_i  = neg_r[k-1];
    end

    assign den_x = {{(v4n_pkg::DremW-v4n_pkg::RootW){1'b0}}, den_i};
    assign take  = (rem_sh >= den_x);

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= take ? (rem_sh - den_x) : rem_sh;
        quo_r[k] <= {quo_i[v4n_pkg::QuoW-2:0], take};
        den_r[k] <= den_i;
        neg_r[k] <= neg_i;
      end
    end
  end

  assign quo     = quo_r[v4n_pkg::DivSteps-1];
  assign neg_out = neg_r[v4n_pkg::DivSteps-1];
endmodule
`default_nettype wire

[tb/v4n_tb_if.sv]
// Types used by the checker of the vector normaliser testbench.
`default_nettype none
package v4n_tb_pkg;
  typedef struct {
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic [31:0] uw;
    logic [32:0] mag;
    logic        zl;
  } unit_vec_t;
endpackage
`default_nettype wire

[tb/v4n_checker.sv]
// Checker that predicts and compares every result transfer of the vector normaliser.
`default_nettype none
module v4n_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  v4n_in_if         in_ch,
  v4n_out_if        out_ch,
  output int        fail_count,
  output int        pending_count
);
  v4n_tb_pkg::unit_vec_t expected_units[$];

  // Digit-by-digit floor square root of a 64-bit value.
  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] scale_lane(logic [31:0] c, logic [63:0] len);
    logic [63:0] a;
    logic [63:0] q;
    if (len == 0) return 32'd0;
    a = c[31] ? 64'(-{32'hFFFFFFFF, c}) : {32'd0, c};
    q = (a << 30) / len;
    if (c[31]) q = -q;
    return q[31:0];
  endfunction

  function automatic v4n_tb_pkg::unit_vec_t normalise(logic [31:0] x, logic [31:0] y,
                                                      logic [31:0] z, logic [31:0] w);
    logic [31:0] lanes [4];
    logic [64:0] total;
    logic [63:0] a;
    logic [63:0] len;
    v4n_tb_pkg::unit_vec_t r;
    lanes[0] = x; lanes[1] = y; lanes[2] = z; lanes[3] = w;
    total = 0;
    for (int i = 0; i < 4; i++) begin
      a = lanes[i][31] ? 64'(-{32'hFFFFFFFF, lanes[i]}) : {32'd0, lanes[i]};
      total = total + 65'(a * a);
    end
    // The sum only overflows 64 bits when every lane is the most negative value.
    len = total[64] ? 64'd1 << 32 : floor_root(total[63:0]);
    r.ux = scale_lane(x, len);
    r.uy = scale_lane(y, len);
    r.uz = scale_lane(z, len);
    r.uw = scale_lane(w, len);
    r.mag = len[32:0];
    r.zl = (len == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    v4n_tb_pkg::unit_vec_t e;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_units.push_back(normalise(in_ch.comp_x, in_ch.comp_y, in_ch.comp_z,
                                           in_ch.comp_w));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected result transfer", $time);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_units.pop_front();
          if (e.ux !== out_ch.unit_x || e.uy !== out_ch.unit_y ||
              e.uz !== out_ch.unit_z || e.uw !== out_ch.unit_w ||
              e.mag !== out_ch.magnitude || e.zl !== out_ch.zero_length) begin
            $display("%0t: expected %h %h %h %h mag %h zl %b, got %h %h %h %h mag %h zl %b",
                     $time, e.ux, e.uy, e.uz, e.uw, e.mag, e.zl, out_ch.unit_x,
                     out_ch.unit_y, out_ch.unit_z, out_ch.unit_w, out_ch.magnitude,
                     out_ch.zero_length);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= expected_units.size();
  end
endmodule
`default_nettype wire

[tb/testbench.sv]
// Top of the vector normaliser testbench: stimulus, stalls and the verdict.
`default_nettype none
module testbench;
  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   cycle_count;
  logic stall_pattern;

  v4n_in_if  in_ch ();
  v4n_out_if out_ch ();

  vector4_normalize u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  v4n_checker u_checker (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                         .fail_count(fail_count), .pending_count(pending_count));

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The receiver stalls in runs whose style changes now and then, including long
  // stretches where it always takes the result.
  initial begin
    out_ch.ready = 1'b0;
    stall_pattern = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) stall_pattern = ~stall_pattern;
      out_ch.ready <= stall_pattern ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // A generous cycle limit stops a hung run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 200000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offers one vector and holds it until the transfer happens.
  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] w);
    in_ch.valid  <= 1'b1;
    in_ch.comp_x <= x;
    in_ch.comp_y <= y;
    in_ch.comp_z <= z;
    in_ch.comp_w <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Picks a component: extremes, small values, powers of two or anything.
  function automatic logic [31:0] pick_lane();
    unique case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 64)) - 32);
      4: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] v [4];
    int burst;
    int n;
    in_ch.valid = 1'b0;
    in_ch.comp_x = 0;
    in_ch.comp_y = 0;
    in_ch.comp_z = 0;
    in_ch.comp_w = 0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed vectors: the zero vector, all lanes most negative (length two to
    // the 32), all most positive, single-lane unit vectors of either sign and
    // the smallest non-zero lengths.
    send_vector(0, 0, 0, 0);
    send_vector(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_vector(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_vector(32'h80000000, 0, 0, 0);
    send_vector(0, 32'h7FFFFFFF, 0, 0);
    send_vector(0, 0, 32'hFFFFFFFF, 0);
    send_vector(0, 0, 0, 32'd1);
    send_vector(32'd1, 32'hFFFFFFFF, 32'd1, 32'hFFFFFFFF);
    send_vector(32'h00010000, 0, 0, 0);
    send_vector(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_vector(32'd3, 32'd4, 0, 0);
    send_vector(32'hFFFF0000, 32'h00010000, 32'hFFFF0000, 32'h00010000);
    send_vector(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);

    // Hold off until the pipeline has drained completely once.
    pause_sender();
    while (pending_count != 0) @(negedge clk);

    n = 0;
    while (n < 1400) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        for (int i = 0; i < 4; i++) v[i] = pick_lane();
        send_vector(v[0], v[1], v[2], v[3]);
        n++;
      end
      if ($urandom_range(0, 2) != 0)
        repeat ($urandom_range(1, 8)) pause_sender();
      else
        in_ch.valid <= 1'b1;
    end
    pause_sender();

    while (pending_count != 0) @(negedge clk);
    repeat (2 * v4n_pkg::Latency) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
